[sv/tcrq_pkg.sv]
// Package for the three-class report queue: sizes, codes, payload structs
// and the control structs shared between the top level and its sequencer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcrq_pkg;

  // Queue geometry
  localparam int PRIO_DEPTH   = 4;
  localparam int TRANS_DEPTH  = 16;
  localparam int REPORT_BYTES = 32;

  localparam int PRIO_PW  = (PRIO_DEPTH > 1) ? $clog2(PRIO_DEPTH) : 1;
  localparam int PRIO_SW  = PRIO_PW + 1;
  localparam int PRIO_CW  = $clog2(PRIO_DEPTH + 1);
  localparam int TRANS_PW = (TRANS_DEPTH > 1) ? $clog2(TRANS_DEPTH) : 1;
  localparam int TRANS_SW = TRANS_PW + 1;
  localparam int TRANS_CW = $clog2(TRANS_DEPTH + 1);

  localparam int CUR_W = $clog2(REPORT_BYTES + 1);
  localparam int IDX_W = (REPORT_BYTES > 1) ? $clog2(REPORT_BYTES) : 1;

  localparam int PRIO_WORDS  = PRIO_DEPTH * REPORT_BYTES;
  localparam int TRANS_WORDS = TRANS_DEPTH * REPORT_BYTES;
  localparam int PRIO_AW     = (PRIO_WORDS > 1) ? $clog2(PRIO_WORDS) : 1;
  localparam int TRANS_AW    = (TRANS_WORDS > 1) ? $clog2(TRANS_WORDS) : 1;

  // Fixed field widths
  localparam int LEN_W  = 6;
  localparam int DROP_W = 16;
  localparam logic [DROP_W-1:0] DROP_MAX = '1;

  // Request codes
  localparam logic [1:0] REQ_ENQUEUE  = 2'd0;
  localparam logic [1:0] REQ_TAKE     = 2'd1;
  localparam logic [1:0] REQ_READY    = 2'd2;
  localparam logic [1:0] REQ_CLASSIFY = 2'd3;

  // Report class codes
  localparam logic [1:0] CLASS_PRIO  = 2'd0;
  localparam logic [1:0] CLASS_TRANS = 2'd1;

  // Classify answers
  localparam logic [1:0] CLS_NONE       = 2'd0;
  localparam logic [1:0] CLS_TRANSITION = 2'd1;
  localparam logic [1:0] CLS_CONTINUOUS = 2'd2;

  typedef enum logic [1:0] {
    TGT_PRIO,
    TGT_TRANS,
    TGT_CONT,
    TGT_DISCARD
  } tgt_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_STREAM
  } seq_state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  report_class;
    logic [7:0]  data_byte;
    logic        byte_last;
    logic [7:0]  id_tag;
    logic [31:0] button_bits;
    logic [7:0]  left_pull;
    logic [7:0]  right_pull;
  } req_t;

  typedef struct packed {
    logic             success;
    logic [7:0]       out_byte;
    logic [7:0]       out_tag;
    logic [LEN_W-1:0] frame_length;
    logic             run_last;
    logic [1:0]       class_out;
  } rsp_t;

  // Start of a stream-out run
  typedef struct packed {
    logic             go;
    logic [CUR_W-1:0] len;
  } seq_cmd_t;

  // Sequencer status, one read per cycle while streaming
  typedef struct packed {
    logic             busy;
    logic             rd_en;
    logic             rd_last;
    logic [IDX_W-1:0] rd_idx;
  } seq_stat_t;

endpackage

`default_nettype wire

[sv/tcrq_ram.sv]
// Generic single-write, single-read memory with registered read data.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module tcrq_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/tcrq_seq.sv]
// Stream-out sequencer: steps a byte index over one stored report.
// Depends on tcrq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcrq_seq
  import tcrq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire seq_cmd_t  cmd_i,
  output seq_stat_t      stat_o
);

  seq_state_e       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CUR_W-1:0] len_q, len_d;
  logic             at_last;

  assign at_last = (CUR_W'(idx_q) == (len_q - CUR_W'(1)));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SEQ_IDLE: begin
        if (cmd_i.go) begin
          state_d = SEQ_STREAM;
        end
      end
      SEQ_STREAM: begin
        if (at_last) begin
          state_d = SEQ_IDLE;
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  // Index and length
  always_comb begin
    idx_d = idx_q;
    len_d = len_q;
    if (state_q == SEQ_IDLE && cmd_i.go) begin
      idx_d = '0;
      len_d = cmd_i.len;
    end else if (state_q == SEQ_STREAM) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  // Outputs
  always_comb begin
    stat_o.busy    = 1'b0;
    stat_o.rd_en   = 1'b0;
    stat_o.rd_last = 1'b0;
    stat_o.rd_idx  = idx_q;
    case (state_q)
      SEQ_IDLE: begin
        stat_o.busy = 1'b0;
      end
      SEQ_STREAM: begin
        stat_o.busy    = 1'b1;
        stat_o.rd_en   = 1'b1;
        stat_o.rd_last = at_last;
      end
      default: stat_o.busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      idx_q   <= '0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
    end
  end

endmodule

`default_nettype wire

[sv/three_class_report_queue_top.sv]
// Top level of the three-class report queue: queue bookkeeping, byte stores
// and result register. Depends on tcrq_pkg, tcrq_ram and tcrq_seq.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel: drive req_i and raise start; the transaction is taken at a
//   rising edge with start high and busy low. Results appear on rsp_o for one
//   cycle each, marked by out_valid_o; the receiver cannot stall them.
//   Enqueue byte, classify and a take that finds nothing (or host not ready)
//   give one result in the cycle after acceptance; busy stays low, so such a
//   transaction may be issued every cycle. Host ready gives no result.
//   A take that delivers a report of N stored bytes raises busy while the
//   sequencer streams and shows the bytes in order, each passing through the
//   store's registered read and the result register, one byte per cycle from
//   the store's single read port; the next transaction can be taken in the
//   cycle the last byte is shown. N runs from 1 to REPORT_BYTES.
//   Reset (rst_ni low, asynchronous) empties all three classes, sets host
//   ready, clears the drop counter, the classify history and any report in
//   progress. The byte stores are not cleared; they are read only after write.
module three_class_report_queue_top
  import tcrq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output rsp_t      rsp_o,
  output logic      out_valid_o
);

  // Bookkeeping state
  logic [CUR_W-1:0]    cursor_q, cursor_d;
  tgt_e                target_q, target_d;
  logic [PRIO_PW-1:0]  wslot_prio_q, wslot_prio_d;
  logic [TRANS_PW-1:0] wslot_trans_q, wslot_trans_d;
  logic [7:0]          wtag_q, wtag_d;
  logic [PRIO_PW-1:0]  prio_head_q, prio_head_d;
  logic [PRIO_CW-1:0]  prio_fill_q, prio_fill_d;
  logic [TRANS_PW-1:0] trans_head_q, trans_head_d;
  logic [TRANS_CW-1:0] trans_fill_q, trans_fill_d;
  logic                newest_valid_q, newest_valid_d;
  logic                host_ready_q, host_ready_d;
  logic [DROP_W-1:0]   drop_q, drop_d;
  logic                sig_seen_q, sig_seen_d;
  logic [31:0]         prev_buttons_q, prev_buttons_d;
  logic [1:0]          prev_pressed_q, prev_pressed_d;

  // Descriptors
  logic [7:0]       prio_tag_q  [PRIO_DEPTH];
  logic [CUR_W-1:0] prio_len_q  [PRIO_DEPTH];
  logic [7:0]       trans_tag_q [TRANS_DEPTH];
  logic [CUR_W-1:0] trans_len_q [TRANS_DEPTH];
  logic [7:0]       newest_tag_q;
  logic [CUR_W-1:0] newest_len_q;

  // Read-side state of the report being streamed
  tgt_e                src_q, src_d;
  logic [PRIO_PW-1:0]  rslot_prio_q, rslot_prio_d;
  logic [TRANS_PW-1:0] rslot_trans_q, rslot_trans_d;
  logic [7:0]          rtag_q, rtag_d;
  logic [CUR_W-1:0]    rlen_q, rlen_d;

  // Result register
  logic             out_valid_q, out_valid_d;
  logic             out_success_q, out_success_d;
  logic [7:0]       out_tag_q, out_tag_d;
  logic [LEN_W-1:0] out_len_q, out_len_d;
  logic             out_last_q, out_last_d;
  logic [1:0]       out_class_q, out_class_d;
  logic             byte_sel_q, byte_sel_d;

  // Commit controls
  logic             commit_prio, commit_trans, commit_cont;
  logic [7:0]       commit_tag;
  logic [CUR_W-1:0] commit_len;

  // Store ports
  logic                prio_we, trans_we, newest_we;
  logic [PRIO_AW-1:0]  prio_waddr, prio_raddr;
  logic [TRANS_AW-1:0] trans_waddr, trans_raddr;
  logic [IDX_W-1:0]    wr_idx;
  logic [7:0]          prio_rdata, trans_rdata, newest_rdata;
  logic [7:0]          byte_mux;

  // Sequencer link
  seq_cmd_t  seq_cmd;
  seq_stat_t seq_stat;

  logic                accept;
  logic                first;
  logic                take_ok;
  logic                res_ok;
  logic [1:0]          res_class;
  logic [1:0]          pressed;
  logic [PRIO_SW-1:0]  prio_sum;
  logic [TRANS_SW-1:0] trans_sum;
  logic [PRIO_PW-1:0]  prio_tail;
  logic [TRANS_PW-1:0] trans_tail;

  assign busy   = seq_stat.busy;
  assign accept = start && !seq_stat.busy;
  assign first  = (cursor_q == '0);

  // Tail slots: head plus fill, wrapped
  always_comb begin
    prio_sum  = PRIO_SW'(prio_head_q) + PRIO_SW'(prio_fill_q);
    trans_sum = TRANS_SW'(trans_head_q) + TRANS_SW'(trans_fill_q);
    if (prio_sum >= PRIO_SW'(PRIO_DEPTH)) begin
      prio_tail = PRIO_PW'(prio_sum - PRIO_SW'(PRIO_DEPTH));
    end else begin
      prio_tail = PRIO_PW'(prio_sum);
    end
    if (trans_sum >= TRANS_SW'(TRANS_DEPTH)) begin
      trans_tail = TRANS_PW'(trans_sum - TRANS_SW'(TRANS_DEPTH));
    end else begin
      trans_tail = TRANS_PW'(trans_sum);
    end
  end

  assign pressed = {(req_i.right_pull != 8'd0), (req_i.left_pull != 8'd0)};
  assign wr_idx  = IDX_W'(cursor_q);

  // Decode the accepted transaction and update bookkeeping
  always_comb begin
    cursor_d       = cursor_q;
    target_d       = target_q;
    wslot_prio_d   = wslot_prio_q;
    wslot_trans_d  = wslot_trans_q;
    wtag_d         = wtag_q;
    prio_head_d    = prio_head_q;
    prio_fill_d    = prio_fill_q;
    trans_head_d   = trans_head_q;
    trans_fill_d   = trans_fill_q;
    newest_valid_d = newest_valid_q;
    host_ready_d   = host_ready_q;
    drop_d         = drop_q;
    sig_seen_d     = sig_seen_q;
    prev_buttons_d = prev_buttons_q;
    prev_pressed_d = prev_pressed_q;
    src_d          = src_q;
    rslot_prio_d   = rslot_prio_q;
    rslot_trans_d  = rslot_trans_q;
    rtag_d         = rtag_q;
    rlen_d         = rlen_q;
    commit_prio    = 1'b0;
    commit_trans   = 1'b0;
    commit_cont    = 1'b0;
    commit_tag     = wtag_q;
    commit_len     = cursor_q;
    prio_we        = 1'b0;
    trans_we       = 1'b0;
    newest_we      = 1'b0;
    take_ok        = 1'b0;
    res_ok         = 1'b0;
    res_class      = CLS_NONE;

    if (accept) begin
      case (req_i.req_type)
        REQ_ENQUEUE: begin
          // Open a new report on its first byte
          if (first) begin
            wtag_d = req_i.id_tag;
            if (req_i.report_class == CLASS_PRIO) begin
              if (prio_fill_q >= PRIO_CW'(PRIO_DEPTH)) begin
                target_d = TGT_DISCARD;
              end else begin
                target_d = TGT_PRIO;
              end
            end else if (req_i.report_class == CLASS_TRANS) begin
              target_d = TGT_TRANS;
              if (trans_fill_q >= TRANS_CW'(TRANS_DEPTH)) begin
                // Drop the oldest transition report
                if (trans_head_q == TRANS_PW'(TRANS_DEPTH - 1)) begin
                  trans_head_d = '0;
                end else begin
                  trans_head_d = trans_head_q + TRANS_PW'(1);
                end
                trans_fill_d = trans_fill_q - TRANS_CW'(1);
                if (drop_q != DROP_MAX) begin
                  drop_d = drop_q + DROP_W'(1);
                end
              end
            end else begin
              target_d       = TGT_CONT;
              newest_valid_d = 1'b0;
            end
            wslot_prio_d  = prio_tail;
            wslot_trans_d = trans_tail;
          end

          // Store the byte while room is left
          if (cursor_q < CUR_W'(REPORT_BYTES)) begin
            prio_we   = (target_d == TGT_PRIO);
            trans_we  = (target_d == TGT_TRANS);
            newest_we = (target_d == TGT_CONT);
            cursor_d  = cursor_q + CUR_W'(1);
          end

          case (target_d)
            TGT_DISCARD: res_ok = 1'b0;
            TGT_TRANS:   res_ok = (drop_d == '0);
            default:     res_ok = 1'b1;
          endcase

          // Commit on the final byte
          if (req_i.byte_last) begin
            commit_tag = wtag_d;
            commit_len = cursor_d;
            case (target_d)
              TGT_PRIO: begin
                commit_prio = 1'b1;
                prio_fill_d = prio_fill_d + PRIO_CW'(1);
              end
              TGT_TRANS: begin
                commit_trans = 1'b1;
                trans_fill_d = trans_fill_d + TRANS_CW'(1);
              end
              TGT_CONT: begin
                commit_cont    = 1'b1;
                newest_valid_d = 1'b1;
              end
              default: commit_cont = 1'b0;
            endcase
            cursor_d = '0;
          end
        end

        REQ_TAKE: begin
          // Pick the class to serve: priority, then transition, then latest
          if (host_ready_q && prio_fill_q != '0) begin
            take_ok      = 1'b1;
            src_d        = TGT_PRIO;
            rslot_prio_d = prio_head_q;
            rtag_d       = prio_tag_q[prio_head_q];
            rlen_d       = prio_len_q[prio_head_q];
            if (prio_head_q == PRIO_PW'(PRIO_DEPTH - 1)) begin
              prio_head_d = '0;
            end else begin
              prio_head_d = prio_head_q + PRIO_PW'(1);
            end
            prio_fill_d = prio_fill_q - PRIO_CW'(1);
          end else if (host_ready_q && trans_fill_q != '0) begin
            take_ok       = 1'b1;
            src_d         = TGT_TRANS;
            rslot_trans_d = trans_head_q;
            rtag_d        = trans_tag_q[trans_head_q];
            rlen_d        = trans_len_q[trans_head_q];
            if (trans_head_q == TRANS_PW'(TRANS_DEPTH - 1)) begin
              trans_head_d = '0;
            end else begin
              trans_head_d = trans_head_q + TRANS_PW'(1);
            end
            trans_fill_d = trans_fill_q - TRANS_CW'(1);
          end else if (host_ready_q && newest_valid_q) begin
            take_ok        = 1'b1;
            src_d          = TGT_CONT;
            rtag_d         = newest_tag_q;
            rlen_d         = newest_len_q;
            newest_valid_d = 1'b0;
          end
          if (take_ok) begin
            host_ready_d = 1'b0;
          end
        end

        REQ_READY: begin
          host_ready_d = 1'b1;
        end

        REQ_CLASSIFY: begin
          if (!sig_seen_q || req_i.button_bits != prev_buttons_q ||
              pressed != prev_pressed_q) begin
            res_class = CLS_TRANSITION;
          end else begin
            res_class = CLS_CONTINUOUS;
          end
          sig_seen_d     = 1'b1;
          prev_buttons_d = req_i.button_bits;
          prev_pressed_d = pressed;
        end

        default: res_class = CLS_NONE;
      endcase
    end
  end

  // Start streaming for a take that found a report
  assign seq_cmd.go  = accept && take_ok;
  assign seq_cmd.len = rlen_d;

  tcrq_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (seq_cmd),
    .stat_o (seq_stat)
  );

  // Store addresses: slot times report size plus byte index
  assign prio_waddr  = PRIO_AW'(PRIO_AW'(wslot_prio_d) * PRIO_AW'(REPORT_BYTES)
                       + PRIO_AW'(wr_idx));
  assign trans_waddr = TRANS_AW'(TRANS_AW'(wslot_trans_d) * TRANS_AW'(REPORT_BYTES)
                       + TRANS_AW'(wr_idx));
  assign prio_raddr  = PRIO_AW'(PRIO_AW'(rslot_prio_q) * PRIO_AW'(REPORT_BYTES)
                       + PRIO_AW'(seq_stat.rd_idx));
  assign trans_raddr = TRANS_AW'(TRANS_AW'(rslot_trans_q) * TRANS_AW'(REPORT_BYTES)
                       + TRANS_AW'(seq_stat.rd_idx));

  tcrq_ram #(.DEPTH(PRIO_WORDS), .WIDTH(8)) u_prio_ram (
    .clk_i   (clk_i),
    .we_i    (prio_we),
    .waddr_i (prio_waddr),
    .wdata_i (req_i.data_byte),
    .re_i    (seq_stat.rd_en && src_q == TGT_PRIO),
    .raddr_i (prio_raddr),
    .rdata_o (prio_rdata)
  );

  tcrq_ram #(.DEPTH(TRANS_WORDS), .WIDTH(8)) u_trans_ram (
    .clk_i   (clk_i),
    .we_i    (trans_we),
    .waddr_i (trans_waddr),
    .wdata_i (req_i.data_byte),
    .re_i    (seq_stat.rd_en && src_q == TGT_TRANS),
    .raddr_i (trans_raddr),
    .rdata_o (trans_rdata)
  );

  tcrq_ram #(.DEPTH(REPORT_BYTES), .WIDTH(8)) u_newest_ram (
    .clk_i   (clk_i),
    .we_i    (newest_we),
    .waddr_i (wr_idx),
    .wdata_i (req_i.data_byte),
    .re_i    (seq_stat.rd_en && src_q == TGT_CONT),
    .raddr_i (seq_stat.rd_idx),
    .rdata_o (newest_rdata)
  );

  // Build the next result
  always_comb begin
    out_valid_d   = 1'b0;
    out_success_d = 1'b0;
    out_tag_d     = 8'd0;
    out_len_d     = '0;
    out_last_d    = 1'b1;
    out_class_d   = CLS_NONE;
    byte_sel_d    = 1'b0;
    if (seq_stat.rd_en) begin
      out_valid_d   = 1'b1;
      out_success_d = 1'b1;
      out_tag_d     = rtag_q;
      out_len_d     = LEN_W'(rlen_q);
      out_last_d    = seq_stat.rd_last;
      byte_sel_d    = 1'b1;
    end else if (accept && req_i.req_type != REQ_READY && !take_ok) begin
      out_valid_d   = 1'b1;
      out_success_d = res_ok;
      out_class_d   = res_class;
    end
  end

  // Select the streamed byte
  always_comb begin
    case (src_q)
      TGT_PRIO:  byte_mux = prio_rdata;
      TGT_TRANS: byte_mux = trans_rdata;
      TGT_CONT:  byte_mux = newest_rdata;
      default:   byte_mux = 8'd0;
    endcase
  end

  assign out_valid_o        = out_valid_q;
  assign rsp_o.success      = out_success_q;
  assign rsp_o.out_byte     = byte_sel_q ? byte_mux : 8'd0;
  assign rsp_o.out_tag      = out_tag_q;
  assign rsp_o.frame_length = out_len_q;
  assign rsp_o.run_last     = out_last_q;
  assign rsp_o.class_out    = out_class_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q       <= '0;
      target_q       <= TGT_PRIO;
      prio_head_q    <= '0;
      prio_fill_q    <= '0;
      trans_head_q   <= '0;
      trans_fill_q   <= '0;
      newest_valid_q <= 1'b0;
      host_ready_q   <= 1'b1;
      drop_q         <= '0;
      sig_seen_q     <= 1'b0;
      prev_buttons_q <= '0;
      prev_pressed_q <= '0;
      src_q          <= TGT_PRIO;
      out_valid_q    <= 1'b0;
      byte_sel_q     <= 1'b0;
    end else begin
      cursor_q       <= cursor_d;
      target_q       <= target_d;
      prio_head_q    <= prio_head_d;
      prio_fill_q    <= prio_fill_d;
      trans_head_q   <= trans_head_d;
      trans_fill_q   <= trans_fill_d;
      newest_valid_q <= newest_valid_d;
      host_ready_q   <= host_ready_d;
      drop_q         <= drop_d;
      sig_seen_q     <= sig_seen_d;
      prev_buttons_q <= prev_buttons_d;
      prev_pressed_q <= prev_pressed_d;
      src_q          <= src_d;
      out_valid_q    <= out_valid_d;
      byte_sel_q     <= byte_sel_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    wslot_prio_q  <= wslot_prio_d;
    wslot_trans_q <= wslot_trans_d;
    wtag_q        <= wtag_d;
    rslot_prio_q  <= rslot_prio_d;
    rslot_trans_q <= rslot_trans_d;
    rtag_q        <= rtag_d;
    rlen_q        <= rlen_d;
    out_success_q <= out_success_d;
    out_tag_q     <= out_tag_d;
    out_len_q     <= out_len_d;
    out_last_q    <= out_last_d;
    out_class_q   <= out_class_d;
  end

  // Descriptor writes on commit
  always_ff @(posedge clk_i) begin
    if (commit_prio) begin
      prio_tag_q[wslot_prio_d] <= commit_tag;
      prio_len_q[wslot_prio_d] <= commit_len;
    end
    if (commit_trans) begin
      trans_tag_q[wslot_trans_d] <= commit_tag;
      trans_len_q[wslot_trans_d] <= commit_len;
    end
    if (commit_cont) begin
      newest_tag_q <= commit_tag;
      newest_len_q <= commit_len;
    end
  end

endmodule

`default_nettype wire

[sv/tcrq_checker.sv]
// Port-level checker for the three-class report queue, bound to the top.
// Depends on tcrq_pkg and three_class_report_queue_top.
`timescale 1ns / 1ps
`default_nettype none

module tcrq_checker
  import tcrq_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire req_t req_i,
  input wire rsp_t rsp_i,
  input wire logic out_valid_i
);

  // A streamed report continues until its last byte
  a_stream_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !rsp_i.run_last |=> out_valid_i)
    else $error("report stream broke before its last byte");

  // Classify answers only in a classify result
  a_class_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && rsp_i.class_out != CLS_NONE |-> !rsp_i.success && rsp_i.run_last)
    else $error("classify result carries success or continuation");

  // A classify transaction answers in the next cycle
  a_classify_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.req_type == REQ_CLASSIFY
    |=> out_valid_i && (rsp_i.class_out == CLS_TRANSITION ||
                        rsp_i.class_out == CLS_CONTINUOUS))
    else $error("classify transaction gave no answer");

  // Host ready gives no result
  a_ready_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.req_type == REQ_READY |=> !out_valid_i)
    else $error("host ready transaction produced a result");

  // Payload bytes only come with a delivered report
  a_byte_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && rsp_i.out_byte != 8'd0 |-> rsp_i.success && rsp_i.frame_length != '0)
    else $error("payload byte outside a delivered report");

endmodule

bind three_class_report_queue_top tcrq_checker u_tcrq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .req_i       (req_i),
  .rsp_i       (rsp_o),
  .out_valid_i (out_valid_o)
);

`default_nettype wire

[test/tb_three_class_report_queue_top.sv]
// Testbench for three_class_report_queue_top: directed and random request
// streams checked against an in-bench mirror of the three report queues.
// Depends on tcrq_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_three_class_report_queue_top;
  import tcrq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = REPORT_BYTES + 8;
  localparam int SHOW_MAX    = 20;
  localparam int PHASE_ITEMS = 100;

  // Class codes beyond the two that the package names
  localparam logic [1:0] CLASS_CONT  = 2'd2;
  localparam logic [1:0] CLASS_SPARE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  rsp_t rsp_o;
  logic out_valid_o;

  three_class_report_queue_top DUT (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .req_i,
    .rsp_o,
    .out_valid_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Results owed by the block, oldest first
  rsp_t answers_due[$];
  int   fail_count  = 0;
  int   cycle_count = 0;
  int   n_requests  = 0;
  int   n_checked   = 0;
  int   n_frames    = 0;
  int   n_refused   = 0;
  int   idle_pct    = 0;

  // Mirror of the queue state
  logic [7:0]  prio_mem [PRIO_DEPTH*REPORT_BYTES];
  logic [7:0]  prio_tag [PRIO_DEPTH];
  int          prio_len [PRIO_DEPTH];
  int          prio_head = 0;
  int          prio_fill = 0;
  logic [7:0]  trans_mem [TRANS_DEPTH*REPORT_BYTES];
  logic [7:0]  trans_tag [TRANS_DEPTH];
  int          trans_len [TRANS_DEPTH];
  int          trans_head = 0;
  int          trans_fill = 0;
  logic [7:0]  cont_mem [REPORT_BYTES];
  logic [7:0]  cont_tag;
  int          cont_len;
  bit          cont_valid = 1'b0;
  bit          host_rdy   = 1'b1;
  int          drop_count = 0;
  bit          sig_valid  = 1'b0;
  logic [31:0] sig_buttons = '0;
  logic [1:0]  sig_pressed = '0;
  int          wr_cursor  = 0;
  tgt_e        wr_tgt     = TGT_PRIO;

  function automatic rsp_t mk_rsp(logic ok, logic [7:0] b, logic [7:0] tag, int len,
                                  logic last, logic [1:0] cls);
    rsp_t x;
    x.success      = ok;
    x.out_byte     = b;
    x.out_tag      = tag;
    x.frame_length = len[LEN_W-1:0];
    x.run_last     = last;
    x.class_out    = cls;
    return x;
  endfunction

  // Random content in every field; callers overwrite what matters
  function automatic req_t junk_req();
    req_t r;
    r.req_type     = 2'($urandom_range(3));
    r.report_class = 2'($urandom_range(3));
    r.data_byte    = 8'($urandom_range(255));
    r.byte_last    = 1'($urandom_range(1));
    r.id_tag       = 8'($urandom_range(255));
    r.button_bits  = $urandom;
    r.left_pull    = 8'($urandom_range(255));
    r.right_pull   = 8'($urandom_range(255));
    return r;
  endfunction

  function automatic req_t enq_req(logic [1:0] cls, logic [7:0] data, logic last,
                                   logic [7:0] tag);
    req_t r;
    r = junk_req();
    r.req_type     = REQ_ENQUEUE;
    r.report_class = cls;
    r.data_byte    = data;
    r.byte_last    = last;
    r.id_tag       = tag;
    return r;
  endfunction

  function automatic req_t cmd_req(logic [1:0] code);
    req_t r;
    r = junk_req();
    r.req_type = code;
    return r;
  endfunction

  function automatic req_t sig_req(logic [31:0] btn, logic [7:0] lp, logic [7:0] rp);
    req_t r;
    r = junk_req();
    r.req_type    = REQ_CLASSIFY;
    r.button_bits = btn;
    r.left_pull   = lp;
    r.right_pull  = rp;
    return r;
  endfunction

  // Advance the mirror by one accepted transaction and queue its results
  task automatic mirror_step(input req_t r);
    logic [7:0] frame [REPORT_BYTES];
    logic [7:0] ftag;
    logic [1:0] pressed;
    logic       ok;
    int         flen, slot, i;
    bit         found, change;
    found = 1'b0;
    flen  = 0;
    ftag  = '0;
    case (r.req_type)
      REQ_ENQUEUE: begin
        // Pick the destination on the first byte of a report
        if (wr_cursor == 0) begin
          if (r.report_class == CLASS_PRIO)
            wr_tgt = (prio_fill >= PRIO_DEPTH) ? TGT_DISCARD : TGT_PRIO;
          else if (r.report_class == CLASS_TRANS)
            wr_tgt = TGT_TRANS;
          else
            wr_tgt = TGT_CONT;
          if (wr_tgt == TGT_DISCARD) n_refused++;
          if (wr_tgt == TGT_TRANS && trans_fill >= TRANS_DEPTH) begin
            trans_head = (trans_head + 1) % TRANS_DEPTH;
            trans_fill--;
            if (drop_count < 65535) drop_count++;
          end
          case (wr_tgt)
            TGT_PRIO: begin
              slot = (prio_head + prio_fill) % PRIO_DEPTH;
              prio_tag[slot] = r.id_tag;
              prio_len[slot] = 0;
            end
            TGT_TRANS: begin
              slot = (trans_head + trans_fill) % TRANS_DEPTH;
              trans_tag[slot] = r.id_tag;
              trans_len[slot] = 0;
            end
            TGT_CONT: begin
              cont_valid = 1'b0;
              cont_tag   = r.id_tag;
              cont_len   = 0;
            end
            default: ;
          endcase
        end
        // Store the byte unless the report is already full
        if (wr_cursor < REPORT_BYTES) begin
          case (wr_tgt)
            TGT_PRIO: begin
              slot = (prio_head + prio_fill) % PRIO_DEPTH;
              prio_mem[slot*REPORT_BYTES + wr_cursor] = r.data_byte;
              prio_len[slot] = wr_cursor + 1;
            end
            TGT_TRANS: begin
              slot = (trans_head + trans_fill) % TRANS_DEPTH;
              trans_mem[slot*REPORT_BYTES + wr_cursor] = r.data_byte;
              trans_len[slot] = wr_cursor + 1;
            end
            TGT_CONT: begin
              cont_mem[wr_cursor] = r.data_byte;
              cont_len = wr_cursor + 1;
            end
            default: ;
          endcase
          wr_cursor++;
        end
        ok = (wr_tgt == TGT_DISCARD) ? 1'b0 :
             (wr_tgt == TGT_TRANS) ? (drop_count == 0) : 1'b1;
        // Commit on the final byte
        if (r.byte_last) begin
          case (wr_tgt)
            TGT_PRIO:  prio_fill++;
            TGT_TRANS: trans_fill++;
            TGT_CONT:  cont_valid = 1'b1;
            default: ;
          endcase
          wr_cursor = 0;
        end
        answers_due.push_back(mk_rsp(ok, 8'h00, 8'h00, 0, 1'b1, CLS_NONE));
      end
      REQ_TAKE: begin
        // Serve priority, then transition, then the latest slot
        if (host_rdy && prio_fill > 0) begin
          slot = prio_head;
          for (i = 0; i < REPORT_BYTES; i++) frame[i] = prio_mem[slot*REPORT_BYTES + i];
          ftag      = prio_tag[slot];
          flen      = prio_len[slot];
          prio_head = (prio_head + 1) % PRIO_DEPTH;
          prio_fill--;
          found = 1'b1;
        end else if (host_rdy && trans_fill > 0) begin
          slot = trans_head;
          for (i = 0; i < REPORT_BYTES; i++) frame[i] = trans_mem[slot*REPORT_BYTES + i];
          ftag       = trans_tag[slot];
          flen       = trans_len[slot];
          trans_head = (trans_head + 1) % TRANS_DEPTH;
          trans_fill--;
          found = 1'b1;
        end else if (host_rdy && cont_valid) begin
          frame      = cont_mem;
          ftag       = cont_tag;
          flen       = cont_len;
          cont_valid = 1'b0;
          found = 1'b1;
        end
        if (found) begin
          host_rdy = 1'b0;
          n_frames++;
          if (flen > REPORT_BYTES) flen = REPORT_BYTES;
          if (flen == 0)
            answers_due.push_back(mk_rsp(1'b1, 8'h00, ftag, 0, 1'b1, CLS_NONE));
          for (i = 0; i < flen; i++)
            answers_due.push_back(mk_rsp(1'b1, frame[i], ftag, flen, i == flen - 1,
                                         CLS_NONE));
        end else begin
          answers_due.push_back(mk_rsp(1'b0, 8'h00, 8'h00, 0, 1'b1, CLS_NONE));
        end
      end
      REQ_READY: host_rdy = 1'b1;
      default: begin
        pressed = {r.right_pull != 8'h00, r.left_pull != 8'h00};
        change  = !sig_valid || r.button_bits != sig_buttons || pressed != sig_pressed;
        sig_valid   = 1'b1;
        sig_buttons = r.button_bits;
        sig_pressed = pressed;
        answers_due.push_back(mk_rsp(1'b0, 8'h00, 8'h00, 0, 1'b1,
                                     change ? CLS_TRANSITION : CLS_CONTINUOUS));
      end
    endcase
  endtask

  // Send one transaction, with an optional random hold-off before it
  task automatic issue(input req_t r);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      req_i <= junk_req();
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    mirror_step(r);
    n_requests++;
  endtask

  // Hold the sender until every owed result has come out
  task automatic drain_answers();
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_classify();
    logic [31:0] btn;
    logic [7:0]  lp, rp;
    int          pick;
    pick = $urandom_range(99);
    if (sig_valid && pick < 70) begin
      // Same pressed pattern, trigger values free; sometimes one button flips
      btn = sig_buttons;
      if (pick >= 45) btn[$urandom_range(31)] ^= 1'b1;
      lp = sig_pressed[0] ? 8'($urandom_range(255, 1)) : 8'h00;
      rp = sig_pressed[1] ? 8'($urandom_range(255, 1)) : 8'h00;
    end else begin
      btn = $urandom;
      lp  = ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
      rp  = ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
    end
    issue(sig_req(btn, lp, rp));
  endtask

  task automatic random_side_request();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40)
      issue(cmd_req(REQ_TAKE));
    else if (pick < 60)
      issue(cmd_req(REQ_READY));
    else
      random_classify();
  endtask

  // One report, mostly short; occasionally overlong or cut off
  task automatic random_report();
    int         len, pick, k;
    logic [1:0] cls;
    logic [7:0] tag;
    pick = $urandom_range(99);
    len  = (pick < 85) ? $urandom_range(6, 1) :
           (pick < 95) ? $urandom_range(REPORT_BYTES, 7) :
                         $urandom_range(REPORT_BYTES + 8, REPORT_BYTES + 1);
    cls  = 2'($urandom_range(3));
    tag  = 8'($urandom_range(255));
    for (k = 0; k < len; k++) begin
      if ($urandom_range(99) < 8) random_side_request();
      if (k > 0 && $urandom_range(99) < 2) return;
      issue(enq_req(k == 0 ? cls : 2'($urandom_range(3)), 8'($urandom_range(255)),
                    k == len - 1, k == 0 ? tag : 8'($urandom_range(255))));
    end
  endtask

  task automatic random_traffic(input int count);
    int  base, pick;
    bit  drained;
    base    = n_requests;
    drained = 1'b0;
    while (n_requests < base + count) begin
      if (!drained && n_requests >= base + count / 2) begin
        drain_answers();
        drained = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 50) begin
        random_report();
      end else if (pick < 62) begin
        issue(cmd_req(REQ_READY));
        issue(cmd_req(REQ_TAKE));
      end else if (pick < 92) begin
        random_side_request();
      end else begin
        issue(cmd_req(REQ_ENQUEUE));
      end
    end
  endtask

  // Classify: first call, repeats, trigger value vs pressed state
  task automatic test_classify_history();
    issue(sig_req(32'h0000_0000, 8'h00, 8'h00));
    issue(sig_req(32'h0000_0000, 8'h00, 8'h00));
    issue(sig_req(32'hFFFF_FFFF, 8'hFF, 8'h00));
    issue(sig_req(32'hFFFF_FFFF, 8'h01, 8'h00));
    issue(sig_req(32'hFFFF_FFFF, 8'hFF, 8'h80));
  endtask

  // Latest slot reads empty while its report is still being written
  task automatic test_continuous_in_progress();
    issue(enq_req(CLASS_CONT, 8'h00, 1'b0, 8'hA5));
    issue(cmd_req(REQ_TAKE));
    issue(enq_req(CLASS_PRIO, 8'hFF, 1'b1, 8'h00));
    issue(cmd_req(REQ_TAKE));
    issue(cmd_req(REQ_READY));
  endtask

  // Fill the priority FIFO, refuse one more, then take with and without ready
  task automatic test_priority_refusal();
    int k;
    for (k = 0; k <= PRIO_DEPTH; k++)
      issue(enq_req(CLASS_PRIO, (k % 2 == 0) ? 8'h00 : 8'hFF, 1'b1,
                    (k == 1) ? 8'hFF : 8'(k)));
    issue(cmd_req(REQ_TAKE));
    issue(cmd_req(REQ_TAKE));
    issue(cmd_req(REQ_READY));
  endtask

  // Transition report before any drop, and the spare class code
  task automatic test_mixed_classes();
    issue(enq_req(CLASS_TRANS, 8'h5A, 1'b1, 8'h11));
    issue(enq_req(CLASS_SPARE, 8'hC3, 1'b1, 8'h22));
  endtask

  // Overfill the transition ring so the oldest entries drop
  task automatic test_ring_overflow();
    int k;
    if (wr_cursor != 0) issue(enq_req(CLASS_TRANS, 8'h00, 1'b1, 8'h00));
    for (k = 0; k < TRANS_DEPTH + 2; k++)
      issue(enq_req(CLASS_TRANS, 8'(k), 1'b1, 8'h80 | 8'(k)));
    for (k = 0; k < 3; k++) begin
      issue(cmd_req(REQ_READY));
      issue(cmd_req(REQ_TAKE));
    end
  endtask

  // Check each result against the oldest owed one
  always @(posedge clk_i) begin : check_rsp
    rsp_t want;
    if (rst_ni) begin
      if ($isunknown(out_valid_o)) begin
        fail_count++;
        if (fail_count <= SHOW_MAX) $display("%0t: result strobe unknown", $time);
      end else if (out_valid_o) begin
        if (answers_due.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOW_MAX)
            $display("%0t: unexpected result, expected none, got ok=%0d byte=%02h tag=%02h len=%0d last=%0d cls=%0d",
                     $time, rsp_o.success, rsp_o.out_byte, rsp_o.out_tag,
                     rsp_o.frame_length, rsp_o.run_last, rsp_o.class_out);
        end else begin
          want = answers_due.pop_front();
          n_checked++;
          if (rsp_o.success !== want.success || rsp_o.out_byte !== want.out_byte ||
              rsp_o.out_tag !== want.out_tag ||
              rsp_o.frame_length !== want.frame_length ||
              rsp_o.run_last !== want.run_last || rsp_o.class_out !== want.class_out) begin
            fail_count++;
            if (fail_count <= SHOW_MAX) begin
              $display("%0t: mismatch, expected ok=%0d byte=%02h tag=%02h len=%0d last=%0d cls=%0d",
                       $time, want.success, want.out_byte, want.out_tag,
                       want.frame_length, want.run_last, want.class_out);
              $display("%0t:           actual ok=%0d byte=%02h tag=%02h len=%0d last=%0d cls=%0d",
                       $time, rsp_o.success, rsp_o.out_byte, rsp_o.out_tag,
                       rsp_o.frame_length, rsp_o.run_last, rsp_o.class_out);
            end
          end
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still owed",
               $time, cycle_count, answers_due.size());
      $display("[three_class_report_queue_top] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_classify_history();
    test_continuous_in_progress();
    test_priority_refusal();
    test_mixed_classes();

    idle_pct = 0;
    random_traffic(PHASE_ITEMS);
    idle_pct = 78;
    random_traffic(PHASE_ITEMS);
    idle_pct = 0;
    test_ring_overflow();
    idle_pct = 10;
    random_traffic(PHASE_ITEMS);
    idle_pct = 0;
    random_traffic(PHASE_ITEMS);

    drain_answers();

    $display("Covered %0d requests and %0d checked results; %0d reports streamed out,",
             n_requests, n_checked, n_frames);
    $display("%0d priority reports refused, %0d transition entries overwritten.",
             n_refused, drop_count);
    if (fail_count == 0) begin
      $display("[three_class_report_queue_top] OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("[three_class_report_queue_top] ERROR");
    end
    $finish;
  end

endmodule
